// File: rtl/tes_pkg.sv
// Shared constants, codes and types of the tween easing scheduler.
package tes_pkg;

   localparam int SLOTS     = 16;
   localparam int TIME_BITS = 16;
   localparam int FRAC_BITS = 16;

   localparam int IDX_W   = 4;
   localparam int VAL_W   = FRAC_BITS + 1;
   localparam int OP_W    = TIME_BITS + 1;
   localparam int NUM_W   = 2 * OP_W;
   localparam int CNT_W   = $clog2(FRAC_BITS + 1);

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_IN     = 2'd1;
   localparam logic [1:0] MODE_INOUT  = 2'd2;
   localparam logic [1:0] MODE_OUT    = 2'd3;

   localparam logic [1:0] EVT_START    = 2'd0;
   localparam logic [1:0] EVT_PROGRESS = 2'd1;
   localparam logic [1:0] EVT_FINISH   = 2'd2;

   localparam logic [VAL_W-1:0] EASE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic [1:0]       res;
      logic [IDX_W-1:0] slot;
      logic [VAL_W-1:0] value;
   } evt_type;

endpackage

// File: rtl/tes_ease_unit.sv
// Shared multiplier and restoring divider that compute one eased fraction.
module tes_ease_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tes_pkg::TIME_BITS-1:0]  pos_in,
   input  logic [tes_pkg::TIME_BITS-1:0]  dur_in,
   input  logic [1:0]                     mode_in,
   output logic                           done,
   output logic [tes_pkg::VAL_W-1:0]      value
);

   localparam int OP_W  = tes_pkg::OP_W;
   localparam int NUM_W = tes_pkg::NUM_W;
   localparam int CNT_W = tes_pkg::CNT_W;
   localparam int VAL_W = tes_pkg::VAL_W;

   localparam logic [2:0] E_IDLE = 3'd0;
   localparam logic [2:0] E_SQ   = 3'd1;
   localparam logic [2:0] E_MUL  = 3'd2;
   localparam logic [2:0] E_PREP = 3'd3;
   localparam logic [2:0] E_DIV  = 3'd4;
   localparam logic [2:0] E_DONE = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [tes_pkg::TIME_BITS-1:0] p_ff, d_ff;
   logic [1:0]                    mode_ff;
   logic [NUM_W-1:0]              dd_ff, prod_ff, rem_ff, den_ff;
   logic [VAL_W-1:0]              q_ff;
   logic [CNT_W-1:0]              cnt_ff;

   logic [OP_W-1:0]  p_ext, d_ext, two_p, two_d, t_val, mul_a, mul_b;
   logic             lower_half;
   logic [NUM_W-1:0] mul_out, num_c, den_c, rem_sh;

   assign p_ext      = {1'b0, p_ff};
   assign d_ext      = {1'b0, d_ff};
   assign two_p      = {p_ff, 1'b0};
   assign two_d      = {d_ff, 1'b0};
   assign lower_half = two_p < d_ext;
   assign t_val      = two_p - d_ext;

   always_comb begin
      mul_a = p_ext;
      mul_b = p_ext;
      if (state_ff == E_SQ) begin
         mul_a = d_ext;
         mul_b = d_ext;
      end else begin
         case (mode_ff)
            tes_pkg::MODE_OUT: begin
               mul_b = two_d - p_ext;
            end
            tes_pkg::MODE_INOUT: begin
               if (!lower_half) begin
                  mul_a = t_val;
                  mul_b = two_d - t_val;
               end
            end
            default: begin
               mul_a = p_ext;
            end
         endcase
      end
   end

   assign mul_out = NUM_W'(mul_a) * NUM_W'(mul_b);

   always_comb begin
      num_c = prod_ff;
      den_c = dd_ff;
      case (mode_ff)
         tes_pkg::MODE_LINEAR: begin
            num_c = NUM_W'(p_ff);
            den_c = NUM_W'(d_ff);
         end
         tes_pkg::MODE_INOUT: begin
            if (lower_half) begin
               num_c = prod_ff << 1;
            end else begin
               num_c = dd_ff + prod_ff;
               den_c = dd_ff << 1;
            end
         end
         default: begin
            num_c = prod_ff;
         end
      endcase
   end

   assign rem_sh = rem_ff << 1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE: if (start) state_in = E_SQ;
         E_SQ:   state_in = E_MUL;
         E_MUL:  state_in = E_PREP;
         E_PREP: state_in = (num_c >= den_c) ? E_DONE : E_DIV;
         E_DIV:  if (cnt_ff == CNT_W'(tes_pkg::FRAC_BITS - 1)) state_in = E_DONE;
         E_DONE: state_in = E_IDLE;
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               p_ff    <= pos_in;
               d_ff    <= dur_in;
               mode_ff <= mode_in;
            end
         end
         E_SQ:  dd_ff   <= mul_out;
         E_MUL: prod_ff <= mul_out;
         E_PREP: begin
            rem_ff <= num_c;
            den_ff <= den_c;
            cnt_ff <= '0;
            q_ff   <= (num_c >= den_c) ? tes_pkg::EASE_ONE : '0;
         end
         E_DIV: begin
            cnt_ff <= cnt_ff + 1'b1;
            if (rem_sh >= den_ff) begin
               rem_ff <= rem_sh - den_ff;
               q_ff   <= {q_ff[VAL_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               q_ff   <= {q_ff[VAL_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   assign done  = (state_ff == E_DONE);
   assign value = q_ff;

endmodule

// File: rtl/tes_rsp_buf.sv
// Result output stage: holds one event back so the final beat of a tick gets tlast.
module tes_rsp_buf (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push_valid,
   output logic                              push_ready,
   input  tes_pkg::evt_type                  push_evt,
   input  logic                              flush,
   output logic                              flush_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tes_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // event_slot, eased_value, zero pad
   output logic [1:0]                        rsp_tuser,  // event_res
   output logic                              rsp_tlast
);

   localparam int PAD_W = tes_pkg::RSP_DATA_W - tes_pkg::IDX_W - tes_pkg::VAL_W;

   logic             pend_valid_ff, pend_valid_in;
   logic             out_valid_ff, out_valid_in;
   tes_pkg::evt_type pend_ff, out_ff;
   logic             last_ff;
   logic             out_free, move;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign push_ready  = !pend_valid_ff || out_free;
   assign flush_ready = !pend_valid_ff || out_free;
   assign move        = pend_valid_ff && out_free && (push_valid || flush);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      pend_valid_in = pend_valid_ff;
      if (push_valid && push_ready) begin
         pend_valid_in = 1'b1;
      end else if (flush && move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         pend_ff <= push_evt;
      end
      if (move) begin
         out_ff  <= pend_ff;
         last_ff <= flush;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_ff.value, out_ff.slot};
   assign rsp_tuser  = out_ff.res;
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/tween_easing_scheduler.sv
// Tween easing scheduler: slot table, tick walker and its result stage.
//
// Input channel (req_): one beat is a command. tuser carries the kind: add
// loads a slot, remove frees one, tick advances every active slot by one.
// Add and remove give no result beat.
// A tick walks all 16 slots in index order. A running slot runs the shared
// multiplier twice and a 16-step restoring divider, with its start and
// progress beats, so a tick holds req_tready low from its beat until the walk
// is done, and longer while the result side stalls. req_tready is high only
// while no command is in progress.
// Result channel (rsp_): start, progress and finish events, in slot order.
// The last event of a tick is marked with tlast; the event before it is held
// back one beat, so it leaves once the next event or the tick's end is known.
// A tick with no events gives no beat. If the receiver stalls, the walk halts
// at its next event until the output register drains; nothing is dropped.
// Reset (synchronous, active high) frees every slot and empties the output;
// slot contents are loaded by add before they are used.
module tween_easing_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tes_pkg::REQ_DATA_W-1:0]    req_tdata,  // slot, start_delay, length_ticks, ease_mode, zero pad
   input  logic [1:0]                        req_tuser,  // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tes_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // event_slot, eased_value, zero pad
   output logic [1:0]                        rsp_tuser,  // event_res
   output logic                              rsp_tlast
);

   localparam int SLOTS = tes_pkg::SLOTS;
   localparam int TW    = tes_pkg::TIME_BITS;
   localparam int IDX_W = tes_pkg::IDX_W;
   localparam int VAL_W = tes_pkg::VAL_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_VISIT = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_EASE  = 3'd3;
   localparam logic [2:0] ST_PROG  = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;
   localparam logic [2:0] ST_FLUSH = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff;
   logic [SLOTS-1:0] active_ff;
   logic [TW-1:0]    delay_ff [SLOTS];
   logic [TW-1:0]    dur_ff   [SLOTS];
   logic [TW-1:0]    pos_ff   [SLOTS];
   logic [1:0]       mode_ff  [SLOTS];
   logic [VAL_W-1:0] last_ff  [SLOTS];

   logic             req_fire;
   logic [IDX_W-1:0] cmd_slot;
   logic             slot_ok;
   logic             cur_act;
   logic [TW-1:0]    cur_delay, cur_dur, cur_pos;
   logic [1:0]       cur_mode;
   logic [VAL_W-1:0] cur_last;

   logic             push_valid, push_ready, flush, flush_ready;
   tes_pkg::evt_type push_evt;
   logic             ease_start, ease_done;
   logic [VAL_W-1:0] ease_value;
   logic             advance, at_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cmd_slot   = req_tdata[3:0];
   assign slot_ok    = int'(cmd_slot) < SLOTS;

   assign cur_act   = active_ff[idx_ff];
   assign cur_delay = delay_ff[idx_ff];
   assign cur_dur   = dur_ff[idx_ff];
   assign cur_pos   = pos_ff[idx_ff];
   assign cur_mode  = mode_ff[idx_ff];
   assign cur_last  = last_ff[idx_ff];
   assign at_end    = (int'(idx_ff) == SLOTS - 1);

   always_comb begin
      push_valid = 1'b0;
      push_evt   = '{res: tes_pkg::EVT_START, slot: idx_ff, value: '0};
      case (state_ff)
         ST_START: begin
            push_valid = 1'b1;
         end
         ST_PROG: begin
            push_valid = 1'b1;
            push_evt   = '{res: tes_pkg::EVT_PROGRESS, slot: idx_ff, value: cur_last};
         end
         ST_FIN: begin
            push_valid = 1'b1;
            push_evt   = '{res: tes_pkg::EVT_FINISH, slot: idx_ff, value: cur_last};
         end
         default: begin
         end
      endcase
   end

   assign flush = (state_ff == ST_FLUSH);

   always_comb begin
      state_in   = state_ff;
      ease_start = 1'b0;
      advance    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == tes_pkg::KIND_TICK) state_in = ST_VISIT;
         end
         ST_VISIT: begin
            if (!cur_act || cur_delay != '0) begin
               advance = 1'b1;
            end else if (cur_dur > cur_pos) begin
               if (cur_pos == '0) begin
                  state_in = ST_START;
               end else begin
                  ease_start = 1'b1;
                  state_in   = ST_EASE;
               end
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_START: begin
            if (push_ready) begin
               ease_start = 1'b1;
               state_in   = ST_EASE;
            end
         end
         ST_EASE: begin
            if (ease_done) begin
               if (ease_value != cur_last) begin
                  state_in = ST_PROG;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         ST_PROG, ST_FIN: begin
            if (push_ready) advance = 1'b1;
         end
         ST_FLUSH: begin
            if (flush_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (advance) state_in = at_end ? ST_FLUSH : ST_VISIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         active_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (advance) idx_ff <= at_end ? '0 : idx_ff + 1'b1;
         if (req_fire && slot_ok) begin
            if (req_tuser == tes_pkg::KIND_ADD) active_ff[cmd_slot] <= 1'b1;
            if (req_tuser == tes_pkg::KIND_REMOVE) active_ff[cmd_slot] <= 1'b0;
         end
         if (state_ff == ST_FIN && push_ready) active_ff[idx_ff] <= 1'b0;
      end
   end

   // slot contents: add writes at the command slot, the walk at the visited one
   always_ff @(posedge clock) begin
      if (req_fire && slot_ok && req_tuser == tes_pkg::KIND_ADD) begin
         delay_ff[cmd_slot] <= req_tdata[19:4];
         dur_ff[cmd_slot]   <= req_tdata[35:20];
         mode_ff[cmd_slot]  <= req_tdata[37:36];
         pos_ff[cmd_slot]   <= '0;
         last_ff[cmd_slot]  <= '0;
      end
      if (state_ff == ST_VISIT && cur_act && cur_delay != '0) begin
         delay_ff[idx_ff] <= cur_delay - 1'b1;
      end
      if (ease_start) pos_ff[idx_ff] <= cur_pos + 1'b1;
      if (state_ff == ST_EASE && ease_done) last_ff[idx_ff] <= ease_value;
   end

   tes_ease_unit u_ease (
      .clock   (clock),
      .reset   (reset),
      .start   (ease_start),
      .pos_in  (cur_pos + 1'b1),
      .dur_in  (cur_dur),
      .mode_in (cur_mode),
      .done    (ease_done),
      .value   (ease_value)
   );

   tes_rsp_buf u_rsp (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_evt    (push_evt),
      .flush       (flush),
      .flush_ready (flush_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// File: test/tb.sv
// Testbench of the tween easing scheduler: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [15:0] delay;
      logic [15:0] dur;
      logic [1:0]  emode;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  res;
      logic [3:0]  slot;
      logic [16:0] value;
      logic        last;
   } event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [tes_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [tes_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   tween_easing_scheduler dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // predictor state
   logic        act [16];
   logic [15:0] dly [16];
   logic [15:0] len [16];
   logic [15:0] pos [16];
   logic [1:0]  md  [16];
   logic [16:0] lst [16];

   event_type events_due[$];
   cmd_type   stim[$];
   int        errors = 0;
   int        cycles = 0;
   bit        hold_off = 1'b0;
   bit        stim_done = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [16:0] frac_q16(logic [63:0] num, logic [63:0] den);
      logic [63:0] rem;
      logic [16:0] q;
      rem = num;
      q = '0;
      if (den == 0) return '0;
      if (num >= den) return tes_pkg::EASE_ONE;
      for (int b = 0; b < tes_pkg::FRAC_BITS; b++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [16:0] eased(logic [63:0] p, logic [63:0] d, logic [1:0] m);
      logic [63:0] dd, t;
      dd = d * d;
      case (m)
         tes_pkg::MODE_LINEAR: return frac_q16(p, d);
         tes_pkg::MODE_IN:     return frac_q16(p * p, dd);
         tes_pkg::MODE_OUT:    return frac_q16(p * (2 * d - p), dd);
         default: begin
            if (2 * p < d) return frac_q16(2 * p * p, dd);
            t = 2 * p - d;
            return frac_q16(dd + t * (2 * d - t), 2 * dd);
         end
      endcase
   endfunction

   task automatic apply_cmd(cmd_type c);
      event_type e;
      logic [16:0] v;
      int first;
      first = events_due.size();
      case (c.kind)
         tes_pkg::KIND_ADD: begin
            act[c.slot] = 1'b1; dly[c.slot] = c.delay; len[c.slot] = c.dur;
            md[c.slot] = c.emode; pos[c.slot] = '0; lst[c.slot] = '0;
         end
         tes_pkg::KIND_REMOVE: act[c.slot] = 1'b0;
         tes_pkg::KIND_TICK: begin
            for (int i = 0; i < tes_pkg::SLOTS; i++) begin
               if (!act[i]) continue;
               if (dly[i] > 0) dly[i] = dly[i] - 1;
               else if (len[i] > pos[i]) begin
                  if (pos[i] == 0) begin
                     e = '{tes_pkg::EVT_START, i[3:0], 17'd0, 1'b0};
                     events_due.insert(events_due.size(), e);
                  end
                  pos[i] = pos[i] + 1;
                  v = eased(pos[i], len[i], md[i]);
                  if (v != lst[i]) begin
                     lst[i] = v;
                     e = '{tes_pkg::EVT_PROGRESS, i[3:0], v, 1'b0};
                     events_due.insert(events_due.size(), e);
                  end
               end else begin
                  e = '{tes_pkg::EVT_FINISH, i[3:0], lst[i], 1'b0};
                  events_due.insert(events_due.size(), e);
                  act[i] = 1'b0;
               end
            end
            if (events_due.size() > first) events_due[$].last = 1'b1;
         end
         default: ;
      endcase
   endtask

   function automatic cmd_type mk(logic [1:0] k, logic [3:0] s, logic [15:0] d,
                                  logic [15:0] l, logic [1:0] m);
      cmd_type c;
      c = '{k, s, d, l, m};
      return c;
   endfunction

   task automatic add_row(cmd_type c);
      stim.insert(stim.size(), c);
   endtask

   // sender
   initial begin
      cmd_type c;
      int gap, n;
      for (int i = 0; i < 16; i++) act[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every mode, zero duration, delay, remove, odd kind
      add_row(mk(tes_pkg::KIND_TICK, 0, 0, 0, 0));
      add_row(mk(tes_pkg::KIND_ADD, 0, 0, 0, tes_pkg::MODE_LINEAR));
      add_row(mk(tes_pkg::KIND_ADD, 15, 16'hffff, 16'hffff, tes_pkg::MODE_OUT));
      add_row(mk(tes_pkg::KIND_ADD, 1, 0, 3, tes_pkg::MODE_IN));
      add_row(mk(tes_pkg::KIND_ADD, 2, 1, 4, tes_pkg::MODE_INOUT));
      add_row(mk(tes_pkg::KIND_ADD, 3, 0, 5, tes_pkg::MODE_INOUT));
      add_row(mk(tes_pkg::KIND_ADD, 4, 0, 2, tes_pkg::MODE_OUT));
      add_row(mk(tes_pkg::KIND_ADD, 5, 0, 1, tes_pkg::MODE_LINEAR));
      add_row(mk(tes_pkg::KIND_TICK, 0, 0, 0, 0));
      add_row(mk(2'd3, 7, 16'hffff, 16'hffff, 3));
      add_row(mk(tes_pkg::KIND_REMOVE, 9, 0, 0, 0));
      add_row(mk(tes_pkg::KIND_TICK, 0, 0, 0, 0));
      add_row(mk(tes_pkg::KIND_ADD, 1, 0, 7, tes_pkg::MODE_LINEAR));
      add_row(mk(tes_pkg::KIND_TICK, 0, 0, 0, 0));
      add_row(mk(tes_pkg::KIND_REMOVE, 15, 0, 0, 0));
      for (int i = 0; i < 8; i++) add_row(mk(tes_pkg::KIND_TICK, 0, 0, 0, 0));
      // random part: mostly short tweens and ticks
      for (int i = 0; i < 345; i++) begin
         n = $urandom_range(0, 99);
         c.slot = 4'($urandom); c.emode = 2'($urandom);
         c.delay = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
         c.dur = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
         if (n < 25) c.kind = tes_pkg::KIND_ADD;
         else if (n < 30) c.kind = tes_pkg::KIND_REMOVE;
         else if (n < 32) c.kind = 2'd3;
         else c.kind = tes_pkg::KIND_TICK;
         add_row(c);
      end
      foreach (stim[i]) begin
         gap = (i > 40 && i < 80) ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         c = stim[i];
         req_tvalid <= 1'b1;
         req_tuser <= c.kind;
         req_tdata <= {2'b00, c.emode, c.dur, c.delay, c.slot};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         apply_cmd(c);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // long receiver hold-off while commands keep coming
   initial begin
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   end

   // receiver
   initial begin
      int gap;
      wait (!reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (gap > 0 || hold_off) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // checker
   always @(posedge clock) begin
      event_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (events_due.size() == 0) begin
            $error("unexpected event beat");
            errors++;
         end else begin
            e = events_due.pop_front();
            if (rsp_tuser != e.res) begin
               $error("event_res exp %0d got %0d", e.res, rsp_tuser); errors++;
            end
            if (rsp_tdata[3:0] != e.slot) begin
               $error("event_slot exp %0d got %0d", e.slot, rsp_tdata[3:0]); errors++;
            end
            if (rsp_tdata[20:4] != e.value) begin
               $error("eased_value exp %0d got %0d", e.value, rsp_tdata[20:4]); errors++;
            end
            if (rsp_tlast != e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_tlast); errors++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (events_due.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
